@@ hdl/qtrm_pkg.sv @@
package qtrm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int WORK_MAX_BITS  = 22;
  localparam int WORK_BITS      = (COMPONENT_BITS > WORK_MAX_BITS) ? WORK_MAX_BITS
                                                                   : COMPONENT_BITS;
  localparam int PROD_W   = 2 * WORK_BITS;       // one signed product
  localparam int NORM_W   = 2 * WORK_BITS + 1;   // squared norm, unsigned
  localparam int REM_W    = 2 * WORK_BITS + 2;   // numerator / partial remainder
  localparam int OUT_FRAC = 14;
  localparam int QUO_W    = OUT_FRAC + 2;        // quotient before rounding
  localparam int OUT_W    = 16;
  localparam int N_ENTRY  = 9;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);
  localparam logic [OUT_W-1:0] OUT_MAX   = OUT_W'(32767);
  localparam logic [OUT_W-1:0] OUT_MIN   = OUT_W'(32768);

  typedef struct packed {
    logic [NORM_W-1:0]                n;
    logic                             zero;
    logic [N_ENTRY-1:0]               neg;
    logic [N_ENTRY-1:0][REM_W-1:0]    r;
    logic [N_ENTRY-1:0][QUO_W-1:0]    q;
  } qtrm_lane_t;

endpackage

@@ hdl/qtrm_front.sv @@
module qtrm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qw,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qx,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qy,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qz,
  output logic                                lane_valid,
  output qtrm_pkg::qtrm_lane_t                lane
);
  import qtrm_pkg::*;

  logic signed [WORK_BITS-1:0] w, x, y, z;
  logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic                     v1, v2, v3;
  logic signed [REM_W-1:0]  num [N_ENTRY];
  logic signed [REM_W-1:0]  num_next [N_ENTRY];
  logic [NORM_W-1:0]        n2, n3;
  logic [NORM_W-1:0]        n_next;
  logic [N_ENTRY-1:0]       neg3;
  logic [N_ENTRY-1:0][REM_W-1:0] mag3;

  // keep the top bits of wide components (flooring shift)
  assign w = qw[COMPONENT_BITS-1 -: WORK_BITS];
  assign x = qx[COMPONENT_BITS-1 -: WORK_BITS];
  assign y = qy[COMPONENT_BITS-1 -: WORK_BITS];
  assign z = qz[COMPONENT_BITS-1 -: WORK_BITS];

  always_comb begin
    n_next = NORM_W'(ww) + NORM_W'(xx) + NORM_W'(yy) + NORM_W'(zz);
    num_next[0] = REM_W'(ww) + REM_W'(xx) - REM_W'(yy) - REM_W'(zz);
    num_next[1] = (REM_W'(xy) - REM_W'(wz)) <<< 1;
    num_next[2] = (REM_W'(xz) + REM_W'(wy)) <<< 1;
    num_next[3] = (REM_W'(xy) + REM_W'(wz)) <<< 1;
    num_next[4] = REM_W'(ww) - REM_W'(xx) + REM_W'(yy) - REM_W'(zz);
    num_next[5] = (REM_W'(yz) - REM_W'(wx)) <<< 1;
    num_next[6] = (REM_W'(xz) - REM_W'(wy)) <<< 1;
    num_next[7] = (REM_W'(yz) + REM_W'(wx)) <<< 1;
    num_next[8] = REM_W'(ww) - REM_W'(xx) - REM_W'(yy) + REM_W'(zz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= w * w;  xx <= x * x;  yy <= y * y;  zz <= z * z;
      xy <= x * y;  xz <= x * z;  yz <= y * z;
      wx <= w * x;  wy <= w * y;  wz <= w * z;
      n2 <= n_next;
      for (int i = 0; i < N_ENTRY; i++) begin
        num[i]  <= num_next[i];
        neg3[i] <= num[i][REM_W-1];
        mag3[i] <= num[i][REM_W-1] ? REM_W'(-num[i]) : REM_W'(num[i]);
      end
      n3 <= n2;
    end
  end

  assign lane_valid = v3;

  always_comb begin
    lane.n    = n3;
    lane.zero = (n3 == '0);
    lane.neg  = neg3;
    lane.r    = mag3;
    lane.q    = '0;
  end

endmodule

@@ hdl/qtrm_div_step.sv @@
module qtrm_div_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  qtrm_pkg::qtrm_lane_t in_lane,
  output logic                 out_valid,
  output qtrm_pkg::qtrm_lane_t out_lane
);
  import qtrm_pkg::*;

  qtrm_lane_t             lane_next;
  logic [REM_W-1:0]       rs;
  logic                   ge;

  // one restoring step per lane: compare, subtract, shift in a quotient bit
  always_comb begin
    lane_next = in_lane;
    rs = '0;
    ge = 1'b0;
    for (int i = 0; i < N_ENTRY; i++) begin
      ge = in_lane.r[i] >= REM_W'(in_lane.n);
      rs = ge ? in_lane.r[i] - REM_W'(in_lane.n) : in_lane.r[i];
      lane_next.r[i] = {rs[REM_W-2:0], 1'b0};
      lane_next.q[i] = {in_lane.q[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lane <= lane_next;
    end
  end

endmodule

@@ hdl/qtrm_round.sv @@
module qtrm_round (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     adv,
  input  logic                                     in_valid,
  input  qtrm_pkg::qtrm_lane_t                     in_lane,
  output logic                                     out_valid,
  output logic [qtrm_pkg::N_ENTRY-1:0][qtrm_pkg::OUT_W-1:0] m,
  output logic                                     zero_error
);
  import qtrm_pkg::*;

  logic [N_ENTRY-1:0][OUT_W-1:0] m_next;
  logic [QUO_W:0]                qp;
  logic [QUO_W-1:0]              qr;

  // round half away from zero on the magnitude, then apply sign and clamp
  always_comb begin
    qp = '0;
    qr = '0;
    for (int i = 0; i < N_ENTRY; i++) begin
      qp = {1'b0, in_lane.q[i]} + (QUO_W+1)'(1);
      qr = qp[QUO_W:1];
      if (in_lane.zero) begin
        m_next[i] = '0;
      end else if (in_lane.neg[i]) begin
        m_next[i] = (qr > NEG_LIMIT) ? OUT_MIN : OUT_W'(-qr);
      end else begin
        m_next[i] = (qr > POS_LIMIT) ? OUT_MAX : OUT_W'(qr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m          <= m_next;
      zero_error <= in_lane.zero;
    end
  end

endmodule

@@ hdl/quaternion_to_rotation_matrix.sv @@
// Pipeline: 3 front stages for products, sums and magnitudes,
//   16 restoring-divider stages with one quotient bit each,
//   1 rounding/output stage.
// Throughput: one word per cycle; the whole pipeline holds while out_stall
//   is high and out_valid is set.
// Reset: rst clears the stage valid bits only; data registers are not reset.
module quaternion_to_rotation_matrix (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qw,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qx,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qy,
  input  logic [qtrm_pkg::COMPONENT_BITS-1:0] qz,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [qtrm_pkg::OUT_W-1:0]          m00,
  output logic [qtrm_pkg::OUT_W-1:0]          m01,
  output logic [qtrm_pkg::OUT_W-1:0]          m02,
  output logic [qtrm_pkg::OUT_W-1:0]          m10,
  output logic [qtrm_pkg::OUT_W-1:0]          m11,
  output logic [qtrm_pkg::OUT_W-1:0]          m12,
  output logic [qtrm_pkg::OUT_W-1:0]          m20,
  output logic [qtrm_pkg::OUT_W-1:0]          m21,
  output logic [qtrm_pkg::OUT_W-1:0]          m22,
  output logic                                zero_error
);
  import qtrm_pkg::*;

  logic                          adv;
  logic                          cv   [QUO_W+1];
  qtrm_lane_t                    cl   [QUO_W+1];
  logic [N_ENTRY-1:0][OUT_W-1:0] m;

  // advance unless a finished word is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  qtrm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .qw         (qw),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .lane_valid (cv[0]),
    .lane       (cl[0])
  );

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    qtrm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (cv[s]),
      .in_lane   (cl[s]),
      .out_valid (cv[s+1]),
      .out_lane  (cl[s+1])
    );
  end

  qtrm_round u_round (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (cv[QUO_W]),
    .in_lane    (cl[QUO_W]),
    .out_valid  (out_valid),
    .m          (m),
    .zero_error (zero_error)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_zero_matrix: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_error) |-> (m00 == '0 && m11 == '0 && m22 == '0 && m01 == '0))
    else $error("zero quaternion gave nonzero matrix");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_error) |->
      ($signed(m00) <= 16384 && $signed(m00) >= -16384 &&
       $signed(m12) <= 16384 && $signed(m12) >= -16384))
    else $error("matrix entry beyond unit magnitude");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(m00) && $stable(zero_error)))
    else $error("output word changed under stall");
`endif

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qtrm_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int RSH = (CB > WORK_MAX_BITS) ? CB - WORK_MAX_BITS : 0;
  localparam int N_RANDOM = 750;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic             zero_error;
  } matrix_t;

  typedef struct {
    logic [CB-1:0] w, x, y, z;
    bit            typed;
    matrix_t       m;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] qw = '0, qx = '0, qy = '0, qz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic zero_error;

  matrix_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  quaternion_to_rotation_matrix dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint reduce(logic [CB-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    return v >>> RSH;
  endfunction

  // round(num * 2^14 / den), ties away from zero, then saturate
  function automatic logic [OUT_W-1:0] scale_entry(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag, q;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    q = ((mag << (OUT_FRAC + 1)) / den + 1) >> 1;
    if (neg) return (q > 32768) ? OUT_MIN : OUT_W'(-longint'(q));
    return (q > 32767) ? OUT_MAX : OUT_W'(q);
  endfunction

  function automatic matrix_t rotation_of(logic [CB-1:0] a, b, c, d);
    longint w, x, y, z, ww, xx, yy, zz;
    longint unsigned n;
    matrix_t m;
    w = reduce(a); x = reduce(b); y = reduce(c); z = reduce(d);
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n = ww + xx + yy + zz;
    m = '0;
    if (n == 0) begin
      m.zero_error = 1'b1;
      return m;
    end
    m.m00 = scale_entry(ww + xx - yy - zz, n);
    m.m01 = scale_entry(2 * (x * y - w * z), n);
    m.m02 = scale_entry(2 * (x * z + w * y), n);
    m.m10 = scale_entry(2 * (x * y + w * z), n);
    m.m11 = scale_entry(ww - xx + yy - zz, n);
    m.m12 = scale_entry(2 * (y * z - w * x), n);
    m.m20 = scale_entry(2 * (x * z - w * y), n);
    m.m21 = scale_entry(2 * (y * z + w * x), n);
    m.m22 = scale_entry(ww - xx - yy + zz, n);
    return m;
  endfunction

  function automatic quat_row_t row(int a, int b, int c, int d, bit t = 0,
                                    matrix_t m = '0);
    quat_row_t r;
    r.w = CB'(a); r.x = CB'(b); r.y = CB'(c); r.z = CB'(d);
    r.typed = t; r.m = m;
    return r;
  endfunction

  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return CB'($signed(-(1 << (CB - 1))));
      1: return CB'((1 << (CB - 1)) - 1);
      2: return CB'($signed($urandom_range(0, 6)) - 3);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic send_word(quat_row_t r);
    matrix_t e;
    e = r.typed ? r.m : rotation_of(r.w, r.x, r.y, r.z);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    qw <= r.w; qx <= r.x; qy <= r.y; qz <= r.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(e);
  endtask

  // receiver: random stall bursts, quiet at the end
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    matrix_t got, e;
    if (!rst && out_valid && !out_stall) begin
      got = {m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_error};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h got %h", e, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    quat_row_t dir[$];
    matrix_t ident, flip_x;
    int mx, mn;
    mx = (1 << (CB - 1)) - 1;
    mn = -(1 << (CB - 1));
    ident = '0;
    ident.m00 = 16'sd16384; ident.m11 = 16'sd16384; ident.m22 = 16'sd16384;
    flip_x = '0;
    flip_x.m00 = 16'sd16384; flip_x.m11 = -16'sd16384; flip_x.m22 = -16'sd16384;
    dir.push_back(row(0, 0, 0, 0, 1, matrix_t'(1)));
    dir.push_back(row(mx, 0, 0, 0, 1, ident));
    dir.push_back(row(mn, 0, 0, 0, 1, ident));
    dir.push_back(row(1, 0, 0, 0, 1, ident));
    dir.push_back(row(-1, 0, 0, 0, 1, ident));
    dir.push_back(row(0, mx, 0, 0, 1, flip_x));
    dir.push_back(row(0, mn, 0, 0));
    dir.push_back(row(0, 0, mx, 0));
    dir.push_back(row(0, 0, 0, mn));
    dir.push_back(row(mx, mx, mx, mx));
    dir.push_back(row(mn, mn, mn, mn));
    dir.push_back(row(mx, mn, mx, mn));
    dir.push_back(row(mn, mx, mn, mx));
    dir.push_back(row(1, 1, 1, 1));
    dir.push_back(row(1, -1, 0, 0));
    dir.push_back(row(23170, 23170, 0, 0));
    dir.push_back(row(0, 0, 1, 0));
    dir.push_back(row(-1, -1, -1, -1));
    dir.push_back(row(16384, -16384, 16384, -16384));
    dir.push_back(row(32767, 1, -1, 3));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir[i]) send_word(dir[i]);
    // drain fully once before random traffic
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      quat_row_t rr;
      if (i == N_RANDOM - 150) quiet = 1'b1;
      rr = row(0, 0, 0, 0);
      rr.w = rand_comp(); rr.x = rand_comp(); rr.y = rand_comp(); rr.z = rand_comp();
      send_word(rr);
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
